// File: hw/rtl/ctsc_pkg.sv
// shared types and codes of the complex tridiagonal solver core
package ctsc_pkg;

   localparam int WordBits = 32;

   typedef struct packed {
      logic signed [WordBits-1:0] re;
      logic signed [WordBits-1:0] im;
   } cplx_type;

   // run status codes, higher code wins
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_ZERO_FIRST = 2'd1;
   localparam logic [1:0] ST_ZERO_LATER = 2'd2;
   localparam logic [1:0] ST_DROPPED    = 2'd3;

   typedef enum logic {
      AR_CMUL,
      AR_CDIV
   } ar_op_type;

   typedef enum logic [2:0] {
      X_R,
      X_PU,
      X_A,
      X_T,
      X_G
   } x_sel_type;

   typedef enum logic [1:0] {
      Y_B,
      Y_PV,
      Y_G,
      Y_U
   } y_sel_type;

   typedef enum logic [3:0] {
      MV_NONE,
      MV_ROW0,
      MV_G,
      MV_PIVOT,
      MV_RHS,
      MV_U,
      MV_PU,
      MV_BACK_LD,
      MV_BACK,
      MV_CLEAR
   } move_type;

   typedef struct packed {
      logic       load_in;
      logic       ar_start;
      ar_op_type  ar_op;
      x_sel_type  ar_x;
      y_sel_type  ar_y;
      move_type   mv;
      logic       f_wr;
      logic       p_wr;
      logic       out_en;
      logic       out_last;
      logic [5:0] out_index;
      logic [1:0] out_status;
   } cmd_type;

   typedef struct packed {
      logic b_zero;
      logic pv_zero;
      logic ar_done;
   } sts_type;

endpackage

// File: hw/rtl/ctsc_arith.sv
// iterative complex multiply and divide unit with one shared multiplier
module ctsc_arith #(
   parameter int FRAC_BITS = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  ctsc_pkg::ar_op_type     op,
   input  ctsc_pkg::cplx_type      x,
   input  ctsc_pkg::cplx_type      y,
   output logic                    done,
   output ctsc_pkg::cplx_type      res
);

   localparam int QBits = 31;
   localparam int ItBits = $clog2(QBits);
   localparam logic [2:0] CmulLast = 3'd3;
   localparam logic [2:0] CdivLast = 3'd5;

   typedef enum logic [2:0] {
      A_IDLE,
      A_MUL,
      A_DRAIN,
      A_CFIN,
      A_DINIT,
      A_DIV,
      A_DFIN
   } a_state_type;

   typedef enum logic [1:0] {
      T_RE,
      T_IM,
      T_DEN
   } tgt_type;

   typedef enum logic [1:0] {
      M_LOAD,
      M_ADD,
      M_SUB
   } mode_type;

   a_state_type          state_ff;
   ctsc_pkg::ar_op_type  op_ff;
   ctsc_pkg::cplx_type   x_ff, y_ff, res_ff;
   logic [2:0]           step_ff;
   logic signed [63:0]   prod_ff;
   tgt_type              tgt_ff;
   mode_type             mode_ff;
   logic                 tag_v_ff;
   logic signed [65:0]   acc_re_ff, acc_im_ff, acc_den_ff;
   logic [64:0]          rem_re_ff, rem_im_ff;
   logic [QBits-1:0]     feed_re_ff, feed_im_ff, q_re_ff, q_im_ff;
   logic                 ovf_re_ff, ovf_im_ff, neg_re_ff, neg_im_ff;
   logic [63:0]          den_ff;
   logic [ItBits-1:0]    it_ff;
   logic                 done_ff;

   logic signed [31:0]   mul_x, mul_y;
   tgt_type              tgt_in;
   mode_type             mode_in;
   logic [2:0]           last_step;
   logic signed [65:0]   prod_ext, acc_sel, acc_new;
   logic [64:0]          mag_re, mag_im;
   logic [95:0]          nw_re, nw_im;
   logic [64:0]          rem2_re, rem2_im;
   logic                 ge_re, ge_im;

   function automatic logic [64:0] abs66(input logic signed [65:0] v);
      logic signed [65:0] n;
      n = -v;
      return v[65] ? n[64:0] : v[64:0];
   endfunction

   function automatic logic signed [31:0] sat_prod(input logic signed [65:0] v);
      logic [64:0] sh;
      sh = abs66(v) >> FRAC_BITS;
      if (v[65]) begin
         return (sh >= 65'h0_8000_0000) ? 32'sh8000_0000 : 32'(32'd0 - sh[31:0]);
      end
      return (sh >= 65'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(sh[31:0]);
   endfunction

   function automatic logic signed [31:0] sat_quot(input logic neg, input logic ovf,
                                                  input logic [QBits-1:0] q);
      if (ovf) begin
         return neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      return neg ? 32'(32'd0 - {1'b0, q}) : 32'({1'b0, q});
   endfunction

   // product schedule
   always_comb begin
      mul_x = x_ff.re;
      mul_y = y_ff.re;
      tgt_in = T_RE;
      mode_in = M_LOAD;
      if (op_ff == ctsc_pkg::AR_CMUL) begin
         unique case (step_ff)
            3'd0: begin mul_x = x_ff.re; mul_y = y_ff.re; tgt_in = T_RE; mode_in = M_LOAD; end
            3'd1: begin mul_x = x_ff.im; mul_y = y_ff.im; tgt_in = T_RE; mode_in = M_SUB; end
            3'd2: begin mul_x = x_ff.re; mul_y = y_ff.im; tgt_in = T_IM; mode_in = M_LOAD; end
            default: begin
               mul_x = x_ff.im; mul_y = y_ff.re; tgt_in = T_IM; mode_in = M_ADD;
            end
         endcase
      end else begin
         unique case (step_ff)
            3'd0: begin mul_x = y_ff.re; mul_y = y_ff.re; tgt_in = T_DEN; mode_in = M_LOAD; end
            3'd1: begin mul_x = y_ff.im; mul_y = y_ff.im; tgt_in = T_DEN; mode_in = M_ADD; end
            3'd2: begin mul_x = x_ff.re; mul_y = y_ff.re; tgt_in = T_RE; mode_in = M_LOAD; end
            3'd3: begin mul_x = x_ff.im; mul_y = y_ff.im; tgt_in = T_RE; mode_in = M_ADD; end
            3'd4: begin mul_x = x_ff.im; mul_y = y_ff.re; tgt_in = T_IM; mode_in = M_LOAD; end
            default: begin
               mul_x = x_ff.re; mul_y = y_ff.im; tgt_in = T_IM; mode_in = M_SUB;
            end
         endcase
      end
      last_step = (op_ff == ctsc_pkg::AR_CMUL) ? CmulLast : CdivLast;
   end

   always_comb begin
      prod_ext = {{2{prod_ff[63]}}, prod_ff};
      unique case (tgt_ff)
         T_RE:    acc_sel = acc_re_ff;
         T_IM:    acc_sel = acc_im_ff;
         default: acc_sel = acc_den_ff;
      endcase
      unique case (mode_ff)
         M_LOAD:  acc_new = prod_ext;
         M_ADD:   acc_new = acc_sel + prod_ext;
         default: acc_new = acc_sel - prod_ext;
      endcase
      mag_re = abs66(acc_re_ff);
      mag_im = abs66(acc_im_ff);
      nw_re = {32'd0, mag_re[63:0]} << FRAC_BITS;
      nw_im = {32'd0, mag_im[63:0]} << FRAC_BITS;
      rem2_re = {rem_re_ff[63:0], feed_re_ff[QBits-1]};
      rem2_im = {rem_im_ff[63:0], feed_im_ff[QBits-1]};
      ge_re = rem2_re >= {1'b0, den_ff};
      ge_im = rem2_im >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         tag_v_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (tag_v_ff) begin
            unique case (tgt_ff)
               T_RE:    acc_re_ff <= acc_new;
               T_IM:    acc_im_ff <= acc_new;
               default: acc_den_ff <= acc_new;
            endcase
         end
         unique case (state_ff)
            A_IDLE: begin
               if (start) begin
                  op_ff <= op;
                  x_ff <= x;
                  y_ff <= y;
                  step_ff <= 3'd0;
                  state_ff <= A_MUL;
               end
            end
            A_MUL: begin
               prod_ff <= mul_x * mul_y;
               tgt_ff <= tgt_in;
               mode_ff <= mode_in;
               tag_v_ff <= 1'b1;
               step_ff <= step_ff + 3'd1;
               if (step_ff == last_step) begin
                  state_ff <= A_DRAIN;
               end
            end
            A_DRAIN: begin
               tag_v_ff <= 1'b0;
               state_ff <= (op_ff == ctsc_pkg::AR_CMUL) ? A_CFIN : A_DINIT;
            end
            A_CFIN: begin
               res_ff.re <= sat_prod(acc_re_ff);
               res_ff.im <= sat_prod(acc_im_ff);
               done_ff <= 1'b1;
               state_ff <= A_IDLE;
            end
            A_DINIT: begin
               den_ff <= acc_den_ff[63:0];
               rem_re_ff <= nw_re[95:QBits];
               rem_im_ff <= nw_im[95:QBits];
               feed_re_ff <= nw_re[QBits-1:0];
               feed_im_ff <= nw_im[QBits-1:0];
               ovf_re_ff <= nw_re[95:QBits] >= {1'b0, acc_den_ff[63:0]};
               ovf_im_ff <= nw_im[95:QBits] >= {1'b0, acc_den_ff[63:0]};
               neg_re_ff <= acc_re_ff[65];
               neg_im_ff <= acc_im_ff[65];
               q_re_ff <= '0;
               q_im_ff <= '0;
               it_ff <= '0;
               state_ff <= A_DIV;
            end
            A_DIV: begin
               rem_re_ff <= ge_re ? rem2_re - {1'b0, den_ff} : rem2_re;
               rem_im_ff <= ge_im ? rem2_im - {1'b0, den_ff} : rem2_im;
               q_re_ff <= {q_re_ff[QBits-2:0], ge_re};
               q_im_ff <= {q_im_ff[QBits-2:0], ge_im};
               feed_re_ff <= feed_re_ff << 1;
               feed_im_ff <= feed_im_ff << 1;
               it_ff <= it_ff + ItBits'(1);
               if (it_ff == ItBits'(QBits - 1)) begin
                  state_ff <= A_DFIN;
               end
            end
            A_DFIN: begin
               // zero divisor forces a zero quotient
               if (den_ff == 64'd0) begin
                  res_ff <= '0;
               end else begin
                  res_ff.re <= sat_quot(neg_re_ff, ovf_re_ff, q_re_ff);
                  res_ff.im <= sat_quot(neg_im_ff, ovf_im_ff, q_im_ff);
               end
               done_ff <= 1'b1;
               state_ff <= A_IDLE;
            end
            default: state_ff <= A_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign res = res_ff;

endmodule

// File: hw/rtl/ctsc_datapath.sv
// operand registers, factor and partial memories and result registers
module ctsc_datapath #(
   parameter int MAX_ROWS  = 64,
   parameter int FRAC_BITS = 24,
   localparam int AW = $clog2(MAX_ROWS)
) (
   input  logic                clock,
   input  logic                reset,
   input  ctsc_pkg::cmd_type   cmd,
   input  logic [AW-1:0]       f_addr,
   input  logic [AW-1:0]       p_addr,
   output ctsc_pkg::sts_type   sts,
   input  ctsc_pkg::cplx_type  in_a,
   input  ctsc_pkg::cplx_type  in_b,
   input  ctsc_pkg::cplx_type  in_c,
   input  ctsc_pkg::cplx_type  in_r,
   output logic                rsp_valid,
   output logic [5:0]          rsp_row_index,
   output ctsc_pkg::cplx_type  rsp_sol,
   output logic [1:0]          rsp_status,
   output logic                rsp_final_out
);

   ctsc_pkg::cplx_type a_ff, b_ff, c_ff, r_ff, pv_ff, pu_ff, g_ff, t_ff, u_ff;
   ctsc_pkg::cplx_type factor_mem_ff [MAX_ROWS];
   ctsc_pkg::cplx_type partial_mem_ff [MAX_ROWS];
   ctsc_pkg::cplx_type f_rd_ff, p_rd_ff;
   ctsc_pkg::cplx_type ar_x, ar_y, ar_res;
   logic               ar_done;
   logic               valid_ff, last_ff;
   logic [5:0]         index_ff;
   logic [1:0]         status_ff;

   function automatic logic signed [31:0] sat_sub1(input logic signed [31:0] p,
                                                   input logic signed [31:0] q);
      logic signed [32:0] d;
      d = {p[31], p} - {q[31], q};
      if (d[32] != d[31]) begin
         return d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      return d[31:0];
   endfunction

   function automatic ctsc_pkg::cplx_type csub(input ctsc_pkg::cplx_type p,
                                              input ctsc_pkg::cplx_type q);
      ctsc_pkg::cplx_type o;
      o.re = sat_sub1(p.re, q.re);
      o.im = sat_sub1(p.im, q.im);
      return o;
   endfunction

   always_comb begin
      unique case (cmd.ar_x)
         ctsc_pkg::X_R:  ar_x = r_ff;
         ctsc_pkg::X_PU: ar_x = pu_ff;
         ctsc_pkg::X_A:  ar_x = a_ff;
         ctsc_pkg::X_T:  ar_x = t_ff;
         default:        ar_x = g_ff;
      endcase
      unique case (cmd.ar_y)
         ctsc_pkg::Y_B:  ar_y = b_ff;
         ctsc_pkg::Y_PV: ar_y = pv_ff;
         ctsc_pkg::Y_G:  ar_y = g_ff;
         default:        ar_y = u_ff;
      endcase
   end

   ctsc_arith #(
      .FRAC_BITS(FRAC_BITS)
   ) u_arith (
      .clock(clock),
      .reset(reset),
      .start(cmd.ar_start),
      .op(cmd.ar_op),
      .x(ar_x),
      .y(ar_y),
      .done(ar_done),
      .res(ar_res)
   );

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         a_ff <= in_a;
         b_ff <= in_b;
         c_ff <= in_c;
         r_ff <= in_r;
      end
      unique case (cmd.mv)
         ctsc_pkg::MV_ROW0: begin
            pv_ff <= b_ff;
            pu_ff <= c_ff;
         end
         ctsc_pkg::MV_G:     g_ff <= ar_res;
         ctsc_pkg::MV_PIVOT: pv_ff <= csub(b_ff, ar_res);
         ctsc_pkg::MV_RHS:   t_ff <= csub(r_ff, ar_res);
         ctsc_pkg::MV_U:     u_ff <= ar_res;
         ctsc_pkg::MV_PU:    pu_ff <= c_ff;
         ctsc_pkg::MV_BACK_LD: begin
            g_ff <= f_rd_ff;
            t_ff <= p_rd_ff;
         end
         ctsc_pkg::MV_BACK:  u_ff <= csub(t_ff, ar_res);
         ctsc_pkg::MV_CLEAR: begin
            pv_ff <= '0;
            pu_ff <= '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.f_wr) begin
         factor_mem_ff[f_addr] <= g_ff;
      end
      f_rd_ff <= factor_mem_ff[f_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.p_wr) begin
         partial_mem_ff[p_addr] <= u_ff;
      end
      p_rd_ff <= partial_mem_ff[p_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.out_en;
      end
      index_ff <= cmd.out_index;
      status_ff <= cmd.out_status;
      last_ff <= cmd.out_last;
   end

   assign sts.b_zero = (b_ff.re == 32'sd0) && (b_ff.im == 32'sd0);
   assign sts.pv_zero = (pv_ff.re == 32'sd0) && (pv_ff.im == 32'sd0);
   assign sts.ar_done = ar_done;

   assign rsp_valid = valid_ff;
   assign rsp_row_index = index_ff;
   assign rsp_sol = p_rd_ff;
   assign rsp_status = status_ff;
   assign rsp_final_out = valid_ff & last_ff;

endmodule

// File: hw/rtl/ctsc_ctrl.sv
// sequencer for forward elimination, back substitution and emission
module ctsc_ctrl #(
   parameter int MAX_ROWS = 64,
   localparam int AW = $clog2(MAX_ROWS),
   localparam int CW = $clog2(MAX_ROWS + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               final_row,
   output logic               busy,
   output ctsc_pkg::cmd_type  cmd,
   output logic [AW-1:0]      f_addr,
   output logic [AW-1:0]      p_addr,
   input  ctsc_pkg::sts_type  sts
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_R0_DIV,
      S_G_DIV,
      S_G_WAIT,
      S_G_WR,
      S_AG_WAIT,
      S_AU_MUL,
      S_AU_WAIT,
      S_P_DIV,
      S_P_WAIT,
      S_WR_U,
      S_END,
      S_BS_RD,
      S_BS_LD,
      S_BS_MUL,
      S_BS_WAIT,
      S_BS_WR,
      S_EMIT,
      S_CLEAR
   } state_type;

   state_type     state_ff;
   logic [CW-1:0] row_cnt_ff;
   logic [AW-1:0] k_ff;
   logic [1:0]    sticky_ff;
   logic          final_ff;

   logic          full;
   logic          raise_en;
   logic [1:0]    raise_code;
   logic [AW-1:0] km1;
   logic          emit_last;

   assign full = row_cnt_ff == CW'(MAX_ROWS);
   assign km1 = k_ff - AW'(1);
   assign emit_last = CW'(k_ff) == (row_cnt_ff - CW'(1));
   assign busy = state_ff != S_IDLE;

   always_comb begin
      cmd = '0;
      cmd.ar_op = ctsc_pkg::AR_CMUL;
      cmd.ar_x = ctsc_pkg::X_R;
      cmd.ar_y = ctsc_pkg::Y_B;
      cmd.mv = ctsc_pkg::MV_NONE;
      cmd.out_status = sticky_ff;
      f_addr = row_cnt_ff[AW-1:0];
      p_addr = row_cnt_ff[AW-1:0];
      raise_en = 1'b0;
      raise_code = ctsc_pkg::ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load_in = start;
            raise_en = start && full;
            raise_code = ctsc_pkg::ST_DROPPED;
         end
         S_R0_DIV: begin
            cmd.ar_start = 1'b1;
            cmd.ar_op = ctsc_pkg::AR_CDIV;
            cmd.ar_x = ctsc_pkg::X_R;
            cmd.ar_y = ctsc_pkg::Y_B;
            cmd.mv = ctsc_pkg::MV_ROW0;
            raise_en = sts.b_zero;
            raise_code = ctsc_pkg::ST_ZERO_FIRST;
         end
         S_G_DIV: begin
            cmd.ar_start = 1'b1;
            cmd.ar_op = ctsc_pkg::AR_CDIV;
            cmd.ar_x = ctsc_pkg::X_PU;
            cmd.ar_y = ctsc_pkg::Y_PV;
         end
         S_G_WAIT: begin
            if (sts.ar_done) begin
               cmd.mv = ctsc_pkg::MV_G;
            end
         end
         S_G_WR: begin
            cmd.f_wr = 1'b1;
            cmd.ar_start = 1'b1;
            cmd.ar_op = ctsc_pkg::AR_CMUL;
            cmd.ar_x = ctsc_pkg::X_A;
            cmd.ar_y = ctsc_pkg::Y_G;
         end
         S_AG_WAIT: begin
            if (sts.ar_done) begin
               cmd.mv = ctsc_pkg::MV_PIVOT;
            end
         end
         S_AU_MUL: begin
            cmd.ar_start = 1'b1;
            cmd.ar_op = ctsc_pkg::AR_CMUL;
            cmd.ar_x = ctsc_pkg::X_A;
            cmd.ar_y = ctsc_pkg::Y_U;
            cmd.mv = ctsc_pkg::MV_PU;
            raise_en = sts.pv_zero;
            raise_code = ctsc_pkg::ST_ZERO_LATER;
         end
         S_AU_WAIT: begin
            if (sts.ar_done) begin
               cmd.mv = ctsc_pkg::MV_RHS;
            end
         end
         S_P_DIV: begin
            cmd.ar_start = 1'b1;
            cmd.ar_op = ctsc_pkg::AR_CDIV;
            cmd.ar_x = ctsc_pkg::X_T;
            cmd.ar_y = ctsc_pkg::Y_PV;
         end
         S_P_WAIT: begin
            if (sts.ar_done) begin
               cmd.mv = ctsc_pkg::MV_U;
            end
         end
         S_WR_U: cmd.p_wr = 1'b1;
         S_END: ;
         S_BS_RD: begin
            f_addr = k_ff;
            p_addr = km1;
         end
         S_BS_LD: begin
            f_addr = k_ff;
            p_addr = km1;
            cmd.mv = ctsc_pkg::MV_BACK_LD;
         end
         S_BS_MUL: begin
            p_addr = km1;
            cmd.ar_start = 1'b1;
            cmd.ar_op = ctsc_pkg::AR_CMUL;
            cmd.ar_x = ctsc_pkg::X_G;
            cmd.ar_y = ctsc_pkg::Y_U;
         end
         S_BS_WAIT: begin
            p_addr = km1;
            if (sts.ar_done) begin
               cmd.mv = ctsc_pkg::MV_BACK;
            end
         end
         S_BS_WR: begin
            p_addr = km1;
            cmd.p_wr = 1'b1;
         end
         S_EMIT: begin
            p_addr = k_ff;
            cmd.out_en = 1'b1;
            cmd.out_last = emit_last;
            cmd.out_index = 6'(k_ff);
         end
         S_CLEAR: cmd.mv = ctsc_pkg::MV_CLEAR;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         row_cnt_ff <= '0;
         k_ff <= '0;
         sticky_ff <= ctsc_pkg::ST_OK;
         final_ff <= 1'b0;
      end else begin
         if (raise_en && (raise_code > sticky_ff)) begin
            sticky_ff <= raise_code;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  final_ff <= final_row;
                  priority if (full) begin
                     state_ff <= S_END;
                  end else if (row_cnt_ff == '0) begin
                     state_ff <= S_R0_DIV;
                  end else begin
                     state_ff <= S_G_DIV;
                  end
               end
            end
            S_R0_DIV:  state_ff <= S_P_WAIT;
            S_G_DIV:   state_ff <= S_G_WAIT;
            S_G_WAIT:  if (sts.ar_done) state_ff <= S_G_WR;
            S_G_WR:    state_ff <= S_AG_WAIT;
            S_AG_WAIT: if (sts.ar_done) state_ff <= S_AU_MUL;
            S_AU_MUL:  state_ff <= S_AU_WAIT;
            S_AU_WAIT: if (sts.ar_done) state_ff <= S_P_DIV;
            S_P_DIV:   state_ff <= S_P_WAIT;
            S_P_WAIT:  if (sts.ar_done) state_ff <= S_WR_U;
            S_WR_U: begin
               row_cnt_ff <= row_cnt_ff + CW'(1);
               state_ff <= S_END;
            end
            S_END: begin
               priority if (!final_ff) begin
                  state_ff <= S_IDLE;
               end else if (row_cnt_ff == CW'(1)) begin
                  k_ff <= '0;
                  state_ff <= S_EMIT;
               end else begin
                  k_ff <= AW'(row_cnt_ff - CW'(1));
                  state_ff <= S_BS_RD;
               end
            end
            S_BS_RD:   state_ff <= S_BS_LD;
            S_BS_LD:   state_ff <= S_BS_MUL;
            S_BS_MUL:  state_ff <= S_BS_WAIT;
            S_BS_WAIT: if (sts.ar_done) state_ff <= S_BS_WR;
            S_BS_WR: begin
               k_ff <= km1;
               state_ff <= (k_ff == AW'(1)) ? S_EMIT : S_BS_RD;
            end
            S_EMIT: begin
               k_ff <= k_ff + AW'(1);
               if (emit_last) begin
                  state_ff <= S_CLEAR;
               end
            end
            S_CLEAR: begin
               row_cnt_ff <= '0;
               sticky_ff <= ctsc_pkg::ST_OK;
               final_ff <= 1'b0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// File: hw/rtl/complex_tridiagonal_solver_core.sv
// complex tridiagonal solver core top level: row transfer in, solution transfer out
// row 0 holds busy for one complex divide, each later row for two complex divides
//   in the shared one-bit-per-cycle divider plus two complex multiplies
// after the final row: back substitution row by row, then one
//   solution transfer per cycle in index order; busy stays high until the last one
// results are strobed on rsp_valid for exactly one cycle; the receiver cannot stall
// synchronous active-high reset returns the sequencer idle with an empty system
module complex_tridiagonal_solver_core #(
   parameter int MAX_ROWS  = 64,
   parameter int FRAC_BITS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_lower_re,
   input  logic signed [31:0] req_lower_im,
   input  logic signed [31:0] req_diag_re,
   input  logic signed [31:0] req_diag_im,
   input  logic signed [31:0] req_upper_re,
   input  logic signed [31:0] req_upper_im,
   input  logic signed [31:0] req_rhs_re,
   input  logic signed [31:0] req_rhs_im,
   input  logic               req_final_row,
   output logic               rsp_valid,
   output logic [5:0]         rsp_row_index,
   output logic signed [31:0] rsp_sol_re,
   output logic signed [31:0] rsp_sol_im,
   output logic [1:0]         rsp_status,
   output logic               rsp_final_out
);

   localparam int AW = $clog2(MAX_ROWS);

   ctsc_pkg::cmd_type  cmd;
   ctsc_pkg::sts_type  sts;
   logic [AW-1:0]      f_addr, p_addr;
   ctsc_pkg::cplx_type in_a, in_b, in_c, in_r, sol;

   // pack the row transfer into complex operands
   assign in_a = '{re: req_lower_re, im: req_lower_im};
   assign in_b = '{re: req_diag_re, im: req_diag_im};
   assign in_c = '{re: req_upper_re, im: req_upper_im};
   assign in_r = '{re: req_rhs_re, im: req_rhs_im};

   // sequencer: row count, sticky status, step order
   ctsc_ctrl #(
      .MAX_ROWS(MAX_ROWS)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .final_row(req_final_row),
      .busy(busy),
      .cmd(cmd),
      .f_addr(f_addr),
      .p_addr(p_addr),
      .sts(sts)
   );

   // datapath: operand registers, memories, arithmetic unit
   ctsc_datapath #(
      .MAX_ROWS(MAX_ROWS),
      .FRAC_BITS(FRAC_BITS)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .f_addr(f_addr),
      .p_addr(p_addr),
      .sts(sts),
      .in_a(in_a),
      .in_b(in_b),
      .in_c(in_c),
      .in_r(in_r),
      .rsp_valid(rsp_valid),
      .rsp_row_index(rsp_row_index),
      .rsp_sol(sol),
      .rsp_status(rsp_status),
      .rsp_final_out(rsp_final_out)
   );

   assign rsp_sol_re = sol.re;
   assign rsp_sol_im = sol.im;

   // solution transfers only come out while a run is in progress
   a_rsp_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("solution strobe outside a run");

   // the run ends right after its last solution transfer
   a_end_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_final_out) |=> !busy)
      else $error("busy held after last solution");

   // the arithmetic unit is never restarted on the cycle after a start
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.ar_start |=> !cmd.ar_start)
      else $error("arithmetic unit restarted while running");

endmodule
